/* rtl/core/tmr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer package
// Shared types, register codes and constants for the interval timer.
// ----------------------------------------------------------------------------
package tmr_pkg;

    // Configuration port geometry: six 32-bit registers at 4-byte steps.
    localparam int unsigned CfgAddrW  = 5;
    localparam int unsigned CfgDataW  = 32;
    localparam int unsigned CfgIdxW   = 3;

    // Timer geometry.
    localparam int unsigned TimerW    = 32;
    localparam int unsigned HalfW     = 16;
    localparam int unsigned ReqW      = 2;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_BASE_ADDRESS      = 3'd0,
        CFG_INITIAL_PERIOD    = 3'd1,
        CFG_PERIOD_LOCKED     = 3'd2,
        CFG_FREE_RUNNING      = 3'd3,
        CFG_SNAPSHOT_PRESENT  = 3'd4,
        CFG_INTERRUPT_PRESENT = 3'd5
    } t_cfg_idx;

    // Request codes of an input item.
    typedef enum logic [ReqW-1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req;

    // Register offsets from the base address.
    localparam logic [TimerW-1:0] OFF_STATUS    = 32'd0;
    localparam logic [TimerW-1:0] OFF_CONTROL   = 32'd4;
    localparam logic [TimerW-1:0] OFF_PERIOD_LO = 32'd8;
    localparam logic [TimerW-1:0] OFF_PERIOD_HI = 32'd12;
    localparam logic [TimerW-1:0] OFF_SNAP_LO   = 32'd16;
    localparam logic [TimerW-1:0] OFF_SNAP_HI   = 32'd20;

    // Control register bit positions.
    localparam int unsigned CTRL_ITO   = 0;
    localparam int unsigned CTRL_CONT  = 1;
    localparam int unsigned CTRL_START = 2;
    localparam int unsigned CTRL_STOP  = 3;

    // Static configuration seen by the timer core.
    typedef struct packed {
        logic [TimerW-1:0] base_address;
        logic              period_locked;
        logic              free_running;
        logic              snapshot_present;
        logic              interrupt_present;
    } t_cfg;

    // Load of a new initial period into period and counter.
    typedef struct packed {
        logic              load;
        logic [TimerW-1:0] value;
    } t_period_load;

endpackage : tmr_pkg
`default_nettype wire

/* rtl/core/interval_timer_peripheral.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer peripheral
// 32-bit down-counting timer driven by tick, read and write transfers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one transfer per item: a tick,
//   a register read or a register write, with address and write data.
//   Output channel (o_valid/i_ready) returns one transfer per item: the
//   read data (0 for ticks, writes and unmatched addresses) and the
//   interrupt level after the item.
//   An item is captured in the input register, then the timer state is
//   updated and the result registered in one pass.
//   Throughput is one item per cycle; the input register and the result
//   register hold one item each, so a stalled receiver does not stop the
//   input until both are full; then o_ready drops until the result is taken.
//   The APB port sets base address, initial period and options; pready is
//   always high. Writing the initial period reloads period and counter.
//   Reset (synchronous, active low) clears all state and configuration and
//   empties both registers.
// ----------------------------------------------------------------------------
module interval_timer_peripheral (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tmr_pkg::ReqW-1:0]      i_req_type,
    input  wire logic [tmr_pkg::TimerW-1:0]    i_bus_address,
    input  wire logic [tmr_pkg::HalfW-1:0]     i_write_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [tmr_pkg::HalfW-1:0]     o_read_value,
    output logic                               o_irq_line,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tmr_pkg::CfgAddrW-1:0]  paddr,
    input  wire logic [tmr_pkg::CfgDataW-1:0]  pwdata,
    output logic      [tmr_pkg::CfgDataW-1:0]  prdata,
    output logic                               pready
);
    import tmr_pkg::*;

    t_cfg              cfg;
    t_period_load      load;
    logic              r_in_vld;
    logic [ReqW-1:0]   r_in_req;
    logic [TimerW-1:0] r_in_addr;
    logic [HalfW-1:0]  r_in_wdata;
    logic              r_out_vld;
    logic [HalfW-1:0]  r_out_rdata;
    logic              r_out_irq;
    logic              advance;
    logic              in_xfer;
    logic [HalfW-1:0]  core_rdata;
    logic              core_irq;

    // Handshake: the item moves on when the result register is free or being emptied.
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;
    assign in_xfer = i_valid && o_ready;

    tmr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_load  (load)
    );

    tmr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_load       (load),
        .i_fire       (advance),
        .i_req        (r_in_req),
        .i_addr       (r_in_addr),
        .i_wdata      (r_in_wdata),
        .o_read_value (core_rdata),
        .o_irq_line   (core_irq)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_req   <= i_req_type;
            r_in_addr  <= i_bus_address;
            r_in_wdata <= i_write_value;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rdata <= core_rdata;
            r_out_irq   <= core_irq;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_read_value = r_out_rdata;
    assign o_irq_line   = r_out_irq;

endmodule : interval_timer_peripheral
`default_nettype wire

/* rtl/core/tmr_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer configuration registers
// APB-style register file holding base address, initial period and options.
// ----------------------------------------------------------------------------
module tmr_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tmr_pkg::CfgAddrW-1:0]  paddr,
    input  wire logic [tmr_pkg::CfgDataW-1:0]  pwdata,
    output logic      [tmr_pkg::CfgDataW-1:0]  prdata,
    output logic                               pready,
    output tmr_pkg::t_cfg                      o_cfg,
    output tmr_pkg::t_period_load              o_load
);
    import tmr_pkg::*;

    logic [TimerW-1:0] r_base_address;
    logic [TimerW-1:0] r_initial_period;
    logic              r_period_locked;
    logic              r_free_running;
    logic              r_snapshot_present;
    logic              r_interrupt_present;
    logic              wr_en;
    t_cfg_idx          reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_cfg_idx'(paddr[CfgAddrW-1:2]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address      <= '0;
            r_initial_period    <= '0;
            r_period_locked     <= 1'b0;
            r_free_running      <= 1'b0;
            r_snapshot_present  <= 1'b0;
            r_interrupt_present <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                CFG_BASE_ADDRESS:      r_base_address      <= pwdata;
                CFG_INITIAL_PERIOD:    r_initial_period    <= pwdata;
                CFG_PERIOD_LOCKED:     r_period_locked     <= pwdata[0];
                CFG_FREE_RUNNING:      r_free_running      <= pwdata[0];
                CFG_SNAPSHOT_PRESENT:  r_snapshot_present  <= pwdata[0];
                CFG_INTERRUPT_PRESENT: r_interrupt_present <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            CFG_BASE_ADDRESS:      prdata = r_base_address;
            CFG_INITIAL_PERIOD:    prdata = r_initial_period;
            CFG_PERIOD_LOCKED:     prdata = {{(CfgDataW-1){1'b0}}, r_period_locked};
            CFG_FREE_RUNNING:      prdata = {{(CfgDataW-1){1'b0}}, r_free_running};
            CFG_SNAPSHOT_PRESENT:  prdata = {{(CfgDataW-1){1'b0}}, r_snapshot_present};
            CFG_INTERRUPT_PRESENT: prdata = {{(CfgDataW-1){1'b0}}, r_interrupt_present};
            default:               prdata = '0;
        endcase
    end

    // A write of the initial period also reloads period and counter.
    assign o_load.load  = wr_en && (reg_idx == CFG_INITIAL_PERIOD);
    assign o_load.value = pwdata;

    assign o_cfg.base_address      = r_base_address;
    assign o_cfg.period_locked     = r_period_locked;
    assign o_cfg.free_running      = r_free_running;
    assign o_cfg.snapshot_present  = r_snapshot_present;
    assign o_cfg.interrupt_present = r_interrupt_present;

endmodule : tmr_cfg
`default_nettype wire

/* rtl/core/tmr_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Interval timer core
// Timer state and the single-pass update for one tick, read or write.
// ----------------------------------------------------------------------------
module tmr_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tmr_pkg::t_cfg                 i_cfg,
    input  wire tmr_pkg::t_period_load         i_load,
    input  wire logic                          i_fire,
    input  wire logic [tmr_pkg::ReqW-1:0]      i_req,
    input  wire logic [tmr_pkg::TimerW-1:0]    i_addr,
    input  wire logic [tmr_pkg::HalfW-1:0]     i_wdata,
    output logic      [tmr_pkg::HalfW-1:0]     o_read_value,
    output logic                               o_irq_line
);
    import tmr_pkg::*;

    logic [TimerW-1:0] r_period, n_period;
    logic [TimerW-1:0] r_count, n_count;
    logic [TimerW-1:0] r_snap, n_snap;
    logic              r_timeout, n_timeout;
    logic              r_running, n_running;
    logic              r_irq_en, n_irq_en;
    logic              r_cont, n_cont;
    logic              r_active, n_active;
    logic              r_irq, n_irq;
    logic [TimerW-1:0] offset;
    logic [TimerW-1:0] new_period;

    assign offset = i_addr - i_cfg.base_address;

    // Next state and read data for the current item.
    always_comb begin
        n_period     = r_period;
        n_count      = r_count;
        n_snap       = r_snap;
        n_timeout    = r_timeout;
        n_running    = r_running;
        n_irq_en     = r_irq_en;
        n_cont       = r_cont;
        n_active     = r_active;
        n_irq        = r_irq;
        new_period   = r_period;
        o_read_value = '0;
        case (t_req'(i_req))
            REQ_TICK: begin
                if (r_active) begin
                    if (r_count == '0) begin
                        if (r_irq_en && i_cfg.interrupt_present) begin
                            n_irq = 1'b1;
                        end
                        n_count   = r_period;
                        n_timeout = 1'b1;
                        n_running = i_cfg.free_running || r_cont;
                        n_active  = i_cfg.free_running || r_cont;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            REQ_READ: begin
                case (offset)
                    OFF_STATUS:    o_read_value = {{(HalfW-2){1'b0}}, r_running, r_timeout};
                    OFF_CONTROL:   o_read_value = {{(HalfW-2){1'b0}}, r_cont, r_irq_en};
                    OFF_PERIOD_LO: o_read_value = r_period[HalfW-1:0];
                    OFF_PERIOD_HI: o_read_value = r_period[TimerW-1:HalfW];
                    OFF_SNAP_LO:   o_read_value = i_cfg.snapshot_present ?
                                                  r_snap[HalfW-1:0] : '0;
                    OFF_SNAP_HI:   o_read_value = i_cfg.snapshot_present ?
                                                  r_snap[TimerW-1:HalfW] : '0;
                    default:       o_read_value = '0;
                endcase
            end
            REQ_WRITE: begin
                case (offset)
                    OFF_STATUS: begin
                        n_timeout = 1'b0;
                        if (i_cfg.interrupt_present) begin
                            n_irq = 1'b0;
                        end
                    end
                    OFF_CONTROL: begin
                        n_irq_en = i_wdata[CTRL_ITO];
                        if (!i_wdata[CTRL_ITO] && i_cfg.interrupt_present) begin
                            n_irq = 1'b0;
                        end
                        n_cont = i_wdata[CTRL_CONT];
                        if (i_wdata[CTRL_START]) begin
                            n_running = 1'b1;
                            n_active  = 1'b1;
                        end
                        // Stop wins over start unless the timer is free running.
                        if (i_wdata[CTRL_STOP] && !i_cfg.free_running) begin
                            n_running = 1'b0;
                            n_active  = 1'b0;
                        end
                    end
                    OFF_PERIOD_LO: begin
                        if (!i_cfg.period_locked) begin
                            new_period = {r_period[TimerW-1:HalfW], i_wdata};
                        end
                        n_active = 1'b0;
                        n_period = new_period;
                        n_count  = new_period;
                    end
                    OFF_PERIOD_HI: begin
                        if (!i_cfg.period_locked) begin
                            new_period = {i_wdata, r_period[HalfW-1:0]};
                        end
                        n_active = 1'b0;
                        n_period = new_period;
                        n_count  = new_period;
                    end
                    OFF_SNAP_LO, OFF_SNAP_HI: begin
                        if (i_cfg.snapshot_present) begin
                            n_snap = r_count;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        o_irq_line = n_irq && i_cfg.interrupt_present;
    end

    // Timer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= '0;
            r_count   <= '0;
            r_snap    <= '0;
            r_timeout <= 1'b0;
            r_running <= 1'b0;
            r_irq_en  <= 1'b0;
            r_cont    <= 1'b0;
            r_active  <= 1'b0;
            r_irq     <= 1'b0;
        end else if (i_load.load) begin
            r_period <= i_load.value;
            r_count  <= i_load.value;
        end else if (i_fire) begin
            r_period  <= n_period;
            r_count   <= n_count;
            r_snap    <= n_snap;
            r_timeout <= n_timeout;
            r_running <= n_running;
            r_irq_en  <= n_irq_en;
            r_cont    <= n_cont;
            r_active  <= n_active;
            r_irq     <= n_irq;
        end
    end

`ifndef SYNTHESIS
    // The counter only runs while the running bit is shown.
    a_active_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_running)
        else $error("counter active while running bit is clear");

    // Without an interrupt line the interrupt level never moves.
    a_irq_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cfg.interrupt_present) |=> (r_irq == $past(r_irq)))
        else $error("interrupt level changed with no interrupt line");

    // A tick on an active nonzero counter decrements it by one.
    a_tick_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_load.load && (i_req == REQ_TICK) && r_active && (r_count != '0))
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("tick did not decrement the counter");
`endif

endmodule : tmr_core
`default_nettype wire
